FILE: sv/window_median_image_filter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the window median image filter
// Shared property forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MEDIAN_IMAGE_FILTER_DEFINES_SVH
`define WINDOW_MEDIAN_IMAGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define WMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// Types and constants shared by the window median image filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wmf_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int LINE_W      = 16;
    localparam int WIN_W       = 3;
    localparam int LEN_FIELD_W = 11;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_LINES  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_LENGTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LINES = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_COLS  = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic clear;
        logic push;
        logic start;
    } sel_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/wmf_line_store.sv
// ----------------------------------------------------------------------------
// wmf_line_store
// Single-port-write, single-port-read line memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmf_line_store #(
    parameter int DEPTH = 7168,
    parameter int WIDTH = 16,
    parameter int AW    = 13
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/wmf_rank_select.sv
// ----------------------------------------------------------------------------
// wmf_rank_select
// Bit-serial rank selection: finds the middle element of the loaded window,
// one result bit per cycle from the most significant bit down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmf_rank_select
    import wmf_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int MAX_WINDOW = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sel_ctrl_t             ctrl,
    input  wire logic [PIXEL_BITS-1:0] push_data,
    output logic                       busy,
    output logic      [PIXEL_BITS-1:0] median
);

    localparam int N  = MAX_WINDOW * MAX_WINDOW;
    localparam int CW = $clog2(N + 1);
    localparam int BW = $clog2(PIXEL_BITS + 1);

    logic [PIXEL_BITS-1:0] value_reg [N];
    logic [N-1:0]          active_reg;
    logic [CW-1:0]         fill_reg;
    logic [CW-1:0]         rank_reg;
    logic [BW-1:0]         step_reg;
    logic                  busy_reg;
    logic [PIXEL_BITS-1:0] median_reg;

    logic [N-1:0]  msb;
    logic [N-1:0]  zeros;
    logic [CW-1:0] count0;
    logic          choose0;

    always_comb
    begin
        count0 = '0;
        for (int k = 0; k < N; k++)
        begin
            msb[k]   = value_reg[k][PIXEL_BITS-1];
            zeros[k] = active_reg[k] & ~value_reg[k][PIXEL_BITS-1];
            count0   = count0 + CW'(zeros[k]);
        end
        choose0 = count0 > rank_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (ctrl.push && fill_reg == CW'(k))
            begin
                value_reg[k] <= push_data;
            end
            else if (busy_reg)
            begin
                value_reg[k] <= {value_reg[k][PIXEL_BITS-2:0], 1'b0};
            end
        end
        if (busy_reg)
        begin
            median_reg <= {median_reg[PIXEL_BITS-2:0], ~choose0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            rank_reg   <= '0;
            step_reg   <= '0;
            busy_reg   <= 1'b0;
            active_reg <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                fill_reg <= '0;
            end
            else if (ctrl.push)
            begin
                fill_reg <= fill_reg + CW'(1);
            end

            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= BW'(PIXEL_BITS);
                rank_reg <= fill_reg >> 1;
                for (int k = 0; k < N; k++)
                begin
                    active_reg[k] <= CW'(k) < fill_reg;
                end
            end
            else if (busy_reg)
            begin
                if (choose0)
                begin
                    active_reg <= active_reg & ~msb;
                end
                else
                begin
                    active_reg <= active_reg & msb;
                    rank_reg   <= rank_reg - count0;
                end
                step_reg <= step_reg - BW'(1);
                if (step_reg == BW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign median = median_reg;

endmodule

`default_nettype wire

FILE: sv/window_median_image_filter.sv
// ----------------------------------------------------------------------------
// window_median_image_filter
// Streaming median filter over grayscale frames with a top-left window.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream in scan order; s_tuser high marks a flush
// word that drains delayed results. Filtered pixels leave on the m_ stream
// with the error status in m_tuser and the last pixel of a frame on m_tlast.
// Results trail the input by (wl-1)*length+(wc-1) pixel words.
// One word is processed at a time; a word that only stores a pixel leaves the
// block idle. A border result is read from the line memory in EMIT and BREAD
// and loaded into the output register from DONE. An interior result reads the
// window through the line memory's single read port one pixel per cycle, then
// the median is resolved one bit per cycle. A finished word waits in the
// output register while the next input word is accepted; if the receiver
// stalls, the next result waits until that register is taken. Reset clears
// all counters but the gather address and loads the default frame geometry;
// the line memory needs no clearing. Configuration writes restart the stream;
// the user must make them only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "window_median_image_filter_defines.svh"

module window_median_image_filter
    import wmf_pkg::*;
#(
    parameter int MAX_LINE_LENGTH = 1024,
    parameter int MAX_WINDOW      = 7,
    parameter int PIXEL_BITS      = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // pixel_in
    input  wire logic                  s_tuser,   // kind
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [15:0]           m_tdata,   // pixel_out
    output logic                       m_tuser,   // status
    output logic                       m_tlast    // frame_last
);

    localparam int LW      = $clog2(MAX_LINE_LENGTH);
    localparam int LLW     = $clog2(MAX_LINE_LENGTH + 1);
    localparam int SW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH   = MAX_WINDOW * MAX_LINE_LENGTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int PW      = $clog2(DEPTH + 2);
    localparam int LEN_RST = (640 > MAX_LINE_LENGTH) ? MAX_LINE_LENGTH : 640;
    localparam int WIN_RST = (3 > MAX_WINDOW) ? MAX_WINDOW : 3;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EMIT   = 3'd1;
    localparam logic [2:0] ST_BREAD  = 3'd2;
    localparam logic [2:0] ST_GATHER = 3'd3;
    localparam logic [2:0] ST_GWAIT  = 3'd4;
    localparam logic [2:0] ST_START  = 3'd5;
    localparam logic [2:0] ST_SELECT = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [LINE_W-1:0] nl_reg;
    logic [LLW-1:0]    len_reg;
    logic [WIN_W-1:0]  wl_reg;
    logic [WIN_W-1:0]  wc_reg;

    logic [2:0]        state_reg, state_next;
    logic [LINE_W-1:0] in_line_reg, in_line_next;
    logic [LW-1:0]     in_col_reg, in_col_next;
    logic [SW-1:0]     in_slot_reg, in_slot_next;
    logic [LINE_W-1:0] out_line_reg, out_line_next;
    logic [LW-1:0]     out_col_reg, out_col_next;
    logic [SW-1:0]     out_slot_reg, out_slot_next;
    logic [PW-1:0]     pending_reg, pending_next;
    logic              flush_reg, flush_next;
    logic [WIN_W-1:0]  r_cnt_reg, r_cnt_next;
    logic [WIN_W-1:0]  c_cnt_reg, c_cnt_next;
    logic [SW-1:0]     g_slot_reg, g_slot_next;
    logic [LW-1:0]     g_col_reg, g_col_next;
    logic              rd_vld_reg;
    logic [PIXEL_BITS-1:0] res_pix_reg, res_pix_next;
    logic              res_status_reg, res_status_next;
    logic              res_last_reg, res_last_next;
    logic              res_emit_reg, res_emit_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [PIXEL_BITS-1:0] m_pix_reg;
    logic              m_status_reg, m_last_reg;

    logic              accept;
    logic              err_w;
    logic [PW-1:0]     lag_w;
    logic              out_border;
    logic              out_last;
    logic              in_last;
    logic              mem_we;
    logic [AW-1:0]     waddr, raddr;
    logic [PIXEL_BITS-1:0] rdata;
    sel_ctrl_t         sel_ctrl;
    logic              sel_busy;
    logic [PIXEL_BITS-1:0] sel_median;
    logic [31:0]       len_clamp;
    logic [31:0]       wl_clamp;
    logic [31:0]       wc_clamp;

    assign accept = s_tvalid && s_tready;
    assign err_w  = (32'(nl_reg) < 32'(wl_reg)) || (32'(len_reg) < 32'(wc_reg));
    assign lag_w  = PW'(32'(wl_reg - WIN_W'(1)) * 32'(len_reg)) + PW'(wc_reg - WIN_W'(1));

    assign out_border = (32'(out_line_reg) < 32'(wl_reg))
                     || (32'(out_line_reg) >= 32'(nl_reg) - 32'(wl_reg))
                     || (32'(out_col_reg) < 32'(wc_reg))
                     || (32'(out_col_reg) >= 32'(len_reg) - 32'(wc_reg));
    assign out_last = (32'(out_line_reg) == 32'(nl_reg) - 32'd1)
                   && (32'(out_col_reg) == 32'(len_reg) - 32'd1);
    assign in_last  = (32'(in_line_reg) == 32'(nl_reg) - 32'd1)
                   && (32'(in_col_reg) == 32'(len_reg) - 32'd1);

    assign len_clamp = (cfg_wdata[LEN_FIELD_W-1:0] == '0) ? 32'd1
                     : (32'(cfg_wdata[LEN_FIELD_W-1:0]) > MAX_LINE_LENGTH)
                       ? 32'(MAX_LINE_LENGTH) : 32'(cfg_wdata[LEN_FIELD_W-1:0]);
    assign wl_clamp  = (cfg_wdata[WIN_W-1:0] == '0) ? 32'd1
                     : (32'(cfg_wdata[WIN_W-1:0]) > MAX_WINDOW)
                       ? 32'(MAX_WINDOW) : 32'(cfg_wdata[WIN_W-1:0]);
    assign wc_clamp  = wl_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_reg  <= LINE_W'(480);
            len_reg <= LLW'(LEN_RST);
            wl_reg  <= WIN_W'(WIN_RST);
            wc_reg  <= WIN_W'(WIN_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_LINES:
                begin
                    nl_reg <= (cfg_wdata == '0) ? LINE_W'(1) : cfg_wdata;
                end
                REG_LINE_LENGTH:  len_reg <= LLW'(len_clamp);
                REG_WINDOW_LINES: wl_reg  <= WIN_W'(wl_clamp);
                REG_WINDOW_COLS:  wc_reg  <= WIN_W'(wc_clamp);
                default:          nl_reg  <= nl_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_line_next    = in_line_reg;
        in_col_next     = in_col_reg;
        in_slot_next    = in_slot_reg;
        out_line_next   = out_line_reg;
        out_col_next    = out_col_reg;
        out_slot_next   = out_slot_reg;
        pending_next    = pending_reg;
        flush_next      = flush_reg;
        r_cnt_next      = r_cnt_reg;
        c_cnt_next      = c_cnt_reg;
        g_slot_next     = g_slot_reg;
        g_col_next      = g_col_reg;
        res_pix_next    = res_pix_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        res_emit_next   = res_emit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mem_we          = 1'b0;
        sel_ctrl        = '0;
        raddr           = AW'(32'(g_slot_reg) * MAX_LINE_LENGTH + 32'(g_col_reg));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == KIND_FLUSH)
                    begin
                        if (!err_w && pending_reg != '0)
                        begin
                            flush_next = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        if (err_w)
                        begin
                            res_pix_next    = '0;
                            res_status_next = 1'b1;
                            res_last_next   = in_last;
                            res_emit_next   = 1'b0;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            mem_we       = 1'b1;
                            pending_next = pending_reg + PW'(1);
                            if (pending_next > lag_w)
                            begin
                                flush_next = 1'b0;
                                state_next = ST_EMIT;
                            end
                        end
                        if (32'(in_col_reg) + 32'd1 >= 32'(len_reg))
                        begin
                            in_col_next  = '0;
                            in_slot_next = (32'(in_slot_reg) == MAX_WINDOW - 1)
                                         ? '0 : in_slot_reg + SW'(1);
                            in_line_next = (32'(in_line_reg) + 32'd1 >= 32'(nl_reg))
                                         ? '0 : in_line_reg + LINE_W'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + LW'(1);
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                raddr           = AW'(32'(out_slot_reg) * MAX_LINE_LENGTH + 32'(out_col_reg));
                res_status_next = 1'b0;
                res_last_next   = out_last;
                res_emit_next   = 1'b1;
                if (out_border)
                begin
                    state_next = ST_BREAD;
                end
                else if (flush_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sel_ctrl.clear = 1'b1;
                    r_cnt_next     = '0;
                    c_cnt_next     = '0;
                    g_slot_next    = out_slot_reg;
                    g_col_next     = out_col_reg;
                    state_next     = ST_GATHER;
                end
            end
            ST_BREAD:
            begin
                res_pix_next = rdata;
                state_next   = ST_DONE;
            end
            ST_GATHER:
            begin
                if (c_cnt_reg == wc_reg - WIN_W'(1))
                begin
                    c_cnt_next  = '0;
                    g_col_next  = out_col_reg;
                    r_cnt_next  = r_cnt_reg + WIN_W'(1);
                    g_slot_next = (32'(g_slot_reg) == MAX_WINDOW - 1)
                                ? '0 : g_slot_reg + SW'(1);
                    if (r_cnt_reg == wl_reg - WIN_W'(1))
                    begin
                        state_next = ST_GWAIT;
                    end
                end
                else
                begin
                    c_cnt_next = c_cnt_reg + WIN_W'(1);
                    g_col_next = (32'(g_col_reg) == MAX_LINE_LENGTH - 1)
                               ? '0 : g_col_reg + LW'(1);
                end
            end
            ST_GWAIT:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                sel_ctrl.start = 1'b1;
                state_next     = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (!sel_busy)
                begin
                    res_pix_next = sel_median;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (res_emit_reg)
                    begin
                        pending_next = pending_reg - PW'(1);
                        if (32'(out_col_reg) + 32'd1 >= 32'(len_reg))
                        begin
                            out_col_next  = '0;
                            out_slot_next = (32'(out_slot_reg) == MAX_WINDOW - 1)
                                          ? '0 : out_slot_reg + SW'(1);
                            out_line_next = (32'(out_line_reg) + 32'd1 >= 32'(nl_reg))
                                          ? '0 : out_line_reg + LINE_W'(1);
                        end
                        else
                        begin
                            out_col_next = out_col_reg + LW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        sel_ctrl.push = rd_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_line_reg  <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_line_reg <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            pending_reg  <= '0;
            flush_reg    <= 1'b0;
            r_cnt_reg    <= '0;
            c_cnt_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            res_emit_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            state_reg    <= ST_IDLE;
            in_line_reg  <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_line_reg <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            pending_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= m_tvalid_reg && !m_tready;
        end
        else
        begin
            state_reg    <= state_next;
            in_line_reg  <= in_line_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_line_reg <= out_line_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            pending_reg  <= pending_next;
            flush_reg    <= flush_next;
            r_cnt_reg    <= r_cnt_next;
            c_cnt_reg    <= c_cnt_next;
            rd_vld_reg   <= (state_reg == ST_GATHER);
            res_emit_reg <= res_emit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_slot_reg     <= g_slot_next;
        g_col_reg      <= g_col_next;
        res_pix_reg    <= res_pix_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
        begin
            m_pix_reg    <= res_pix_reg;
            m_status_reg <= res_status_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    assign waddr = AW'(32'(in_slot_reg) * MAX_LINE_LENGTH + 32'(in_col_reg));

    wmf_line_store #(
        .DEPTH (DEPTH),
        .WIDTH (PIXEL_BITS),
        .AW    (AW)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (s_tdata[PIXEL_BITS-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    wmf_rank_select #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_rank_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sel_ctrl),
        .push_data (rdata),
        .busy      (sel_busy),
        .median    (sel_median)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(m_pix_reg);
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `WMF_ASSERT_NOW(a_pending_bound, 1'b1, pending_reg <= lag_w + PW'(1), "pending exceeds lag")
    `WMF_ASSERT_NOW(a_no_gather_on_err, state_reg == ST_GATHER, !err_w, "gather during error")
    `WMF_ASSERT_NOW(a_out_from_done, $rose(m_tvalid), $past(state_reg == ST_DONE), "stray output")
    `WMF_ASSERT_NEXT(a_start_busy, state_reg == ST_START, sel_busy, "selector did not start")

endmodule

`default_nettype wire
